// File: rtl/kdf_pkg.sv
package kdf_pkg;

  localparam int unsigned KeyW     = 6;
  localparam int unsigned KeyRange = 64;
  localparam int unsigned MinHeld  = 3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_MAPRD,
    ST_EVAL,
    ST_FLUSH
  } kdf_state_e;

  typedef struct packed {
    logic present;
    logic reported;
  } kdf_map_entry_t;

  typedef struct packed {
    logic [KeyW-1:0] difference;
    logic [KeyW-1:0] larger_key;
    logic [KeyW-1:0] smaller_key;
    logic            first_found;
  } kdf_result_t;

  typedef struct packed {
    logic push;
    logic flush;
  } kdf_buf_ctl_t;

endpackage

// File: rtl/kdf_ram.sv
module kdf_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/kdf_result_buf.sv
module kdf_result_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kdf_pkg::kdf_buf_ctl_t ctl_i,
  input  kdf_pkg::kdf_result_t  res_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output kdf_pkg::kdf_result_t  out_res_o,
  output logic                 out_last_o
);

  import kdf_pkg::*;

  // The held result waits until the next one, or the end of the run, says
  // whether it is the last of its run.
  logic        hold_valid_q, hold_valid_d;
  kdf_result_t hold_q, hold_d;
  logic        out_valid_q, out_valid_d;
  kdf_result_t out_q, out_d;
  logic        out_last_q, out_last_d;
  logic        out_free;
  logic        move;

  assign out_free = !out_valid_q || out_ready_i;
  assign ready_o  = !hold_valid_q || out_free;
  assign move     = (ctl_i.push || ctl_i.flush) && ready_o && hold_valid_q;

  always_comb begin
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    out_last_d   = out_last_q;
    if (move) begin
      out_valid_d = 1'b1;
      out_d       = hold_q;
      out_last_d  = ctl_i.flush;
    end
    if (ctl_i.push && ready_o) begin
      hold_valid_d = 1'b1;
      hold_d       = res_i;
    end else if (ctl_i.flush && ready_o) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q     <= hold_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule

// File: rtl/key_difference_finder.sv
// Finds pairs of distinct keys whose difference is itself a key already held.
// The input channel (in_valid_i, in_ready_o, key_i) takes one key per
// transaction. Zero keys, keys at or above KEY_LIMIT and repeated keys are
// dropped without a result. Every new key is stored; once three or more are
// held it is paired with each earlier key in arrival order, and every
// difference found for the first time gives one transaction on the output
// channel (out_valid_o, out_ready_i and the result fields). last_of_run_o
// marks the final result caused by a key.
// A dropped zero key or a key at or above KEY_LIMIT is turned away in the idle
// state, a repeated key after a map read. In the walk of a new key, each
// earlier key costs a key list read followed by a map read on the single
// read port of each memory. A result waits behind the output register
// until the next result or the end of the walk is known, so the last one
// is held back until the walk ends.
// After reset the presence and reported maps are cleared one entry a cycle
// while in_ready_o is low.
// A stalled receiver holds the walk once both the output register and the
// result waiting behind it are full; nothing is lost.
module key_difference_finder #(
  parameter int unsigned KEY_LIMIT = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [kdf_pkg::KeyW-1:0]  key_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [kdf_pkg::KeyW-1:0]  difference_o,
  output logic [kdf_pkg::KeyW-1:0]  larger_key_o,
  output logic [kdf_pkg::KeyW-1:0]  smaller_key_o,
  output logic                      first_found_o,
  output logic                      last_of_run_o
);

  import kdf_pkg::*;

  localparam int unsigned MapDepth = (KEY_LIMIT < KeyRange) ? KEY_LIMIT : KeyRange;
  localparam int unsigned IdxW     = $clog2(MapDepth);
  localparam int unsigned CmpW     = KeyW + 1;

  kdf_state_e       state_q, state_d;
  logic [KeyW-1:0]  k_q, k_d;
  logic [IdxW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             any_found_q, any_found_d;
  logic [KeyW-1:0]  d_q, d_d;
  logic [KeyW-1:0]  hi_q, hi_d;
  logic [KeyW-1:0]  lo_q, lo_d;
  logic             d_ok_q, d_ok_d;

  logic             map_we, map_re;
  logic [IdxW-1:0]  map_waddr, map_raddr;
  kdf_map_entry_t   map_wdata, map_rdata;
  logic             list_we, list_re;
  logic [IdxW-1:0]  list_raddr;
  logic [KeyW-1:0]  list_rdata;

  kdf_buf_ctl_t     buf_ctl;
  kdf_result_t      res;
  kdf_result_t      out_res;
  logic             buf_ready;

  logic [KeyW-1:0]  other_key, pair_hi, pair_lo, pair_diff;
  logic             key_ok, hit, emit;

  assign other_key = list_rdata;
  assign pair_hi   = (k_q > other_key) ? k_q : other_key;
  assign pair_lo   = (k_q > other_key) ? other_key : k_q;
  assign pair_diff = pair_hi - pair_lo;

  assign key_ok = (key_i != '0) && ({1'b0, key_i} < CmpW'(MapDepth));
  assign hit    = d_ok_q && map_rdata.present;
  assign emit   = hit && !map_rdata.reported;

  assign res.difference  = d_q;
  assign res.larger_key  = hi_q;
  assign res.smaller_key = lo_q;
  assign res.first_found = hit && !any_found_q;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    count_d     = count_q;
    idx_d       = idx_q;
    any_found_d = any_found_q;
    d_d         = d_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    d_ok_d      = d_ok_q;
    in_ready_o  = 1'b0;
    map_we      = 1'b0;
    map_waddr   = idx_q;
    map_wdata   = '0;
    map_re      = 1'b0;
    map_raddr   = key_i[IdxW-1:0];
    list_we     = 1'b0;
    list_re     = 1'b0;
    list_raddr  = idx_q;
    buf_ctl     = '0;
    unique case (state_q)
      ST_CLEAR: begin
        map_we = 1'b1;
        if (idx_q == IdxW'(MapDepth - 1)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && key_ok) begin
          map_re  = 1'b1;
          k_d     = key_i;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = ST_IDLE;
        if (!map_rdata.present) begin
          map_we            = 1'b1;
          map_waddr         = k_q[IdxW-1:0];
          map_wdata.present = 1'b1;
          list_we           = 1'b1;
          count_d           = count_q + 1'b1;
          if (count_q >= IdxW'(MinHeld - 1)) begin
            idx_d      = '0;
            list_re    = 1'b1;
            list_raddr = '0;
            state_d    = ST_MAPRD;
          end
        end
      end
      ST_MAPRD: begin
        hi_d      = pair_hi;
        lo_d      = pair_lo;
        d_d       = pair_diff;
        d_ok_d    = ({1'b0, pair_diff} < CmpW'(MapDepth)) && (pair_diff != k_q);
        map_re    = 1'b1;
        map_raddr = pair_diff[IdxW-1:0];
        state_d   = ST_EVAL;
      end
      ST_EVAL: begin
        if (!emit || buf_ready) begin
          any_found_d = any_found_q || hit;
          if (emit) begin
            buf_ctl.push       = 1'b1;
            map_we             = 1'b1;
            map_waddr          = d_q[IdxW-1:0];
            map_wdata.present  = 1'b1;
            map_wdata.reported = 1'b1;
          end
          if (idx_q == count_q - IdxW'(MinHeld - 1)) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d      = idx_q + 1'b1;
            list_re    = 1'b1;
            list_raddr = idx_q + 1'b1;
            state_d    = ST_MAPRD;
          end
        end
      end
      ST_FLUSH: begin
        buf_ctl.flush = 1'b1;
        if (buf_ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      count_q     <= '0;
      idx_q       <= '0;
      any_found_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      any_found_q <= any_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    d_q    <= d_d;
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    d_ok_q <= d_ok_d;
  end

  kdf_ram #(
    .Width ($bits(kdf_map_entry_t)),
    .Depth (MapDepth)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  kdf_ram #(
    .Width (KeyW),
    .Depth (MapDepth)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (count_q),
    .wdata_i (k_q),
    .re_i    (list_re),
    .raddr_i (list_raddr),
    .rdata_o (list_rdata)
  );

  kdf_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (buf_ctl),
    .res_i       (res),
    .ready_o     (buf_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res),
    .out_last_o  (last_of_run_o)
  );

  assign difference_o  = out_res.difference;
  assign larger_key_o  = out_res.larger_key;
  assign smaller_key_o = out_res.smaller_key;
  assign first_found_o = out_res.first_found;

  a_found_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_found_q |=> any_found_q)
    else $error("First-found mark was lost.");

  a_no_self_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && map_we) |-> (d_q != k_q))
    else $error("A key was marked as its own difference.");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK && !map_rdata.present) |=> (count_q == $past(count_q) + 1'b1))
    else $error("Key count did not advance on a new key.");

endmodule
